// ----- rtl/core/pls_pkg.sv -----
// pls_pkg: shared types and constants of the percolation lattice seeder.
// No dependencies; used by pls_addr_gen, pls_ctrl, the top level and pls_checker.
package pls_pkg;

  localparam int SITE_W   = 5;
  localparam int THR_W    = 17;
  localparam int SIDE_W   = 7;
  localparam int POS_W    = 6;
  localparam int SAMPLE_W = 16;
  localparam int MODE_W   = 2;
  localparam int STEP_W   = 3;

  // item modes
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_KIND      = 2'd1;
  localparam logic [1:0] REG_SIDE      = 2'd2;

  // site word layout
  localparam int OCC_BIT    = 0;
  localparam int BOND_N_BIT = 1;
  localparam int BOND_E_BIT = 2;
  localparam int BOND_S_BIT = 3;
  localparam int BOND_W_BIT = 4;

  // neighbor slots of the address set; also the read steps of a site-mode read
  localparam int NB_COUNT = 5;
  localparam logic [STEP_W-1:0] NB_A = 3'd0;
  localparam logic [STEP_W-1:0] NB_N = 3'd1;
  localparam logic [STEP_W-1:0] NB_E = 3'd2;
  localparam logic [STEP_W-1:0] NB_S = 3'd3;
  localparam logic [STEP_W-1:0] NB_W = 3'd4;

  localparam logic [STEP_W-1:0] STEP_ZERO = 3'd0;
  localparam logic [STEP_W-1:0] STEP_ONE  = 3'd1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_SITE_SET,
    OP_BOND_SET,
    OP_READ_SITE,
    OP_READ_BOND,
    OP_READ_ZERO
  } op_t;

  typedef struct packed {
    logic [THR_W-1:0]  threshold;
    logic              kind;
    logic [SIDE_W-1:0] side;
  } cfg_t;

  typedef struct packed {
    logic occupied;
    logic bond_north;
    logic bond_east;
    logic bond_south;
    logic bond_west;
  } res_t;

endpackage

// ----- rtl/core/pls_ram.sv -----
// pls_ram: generic RAM, one write port and one read port, registered read.
// No dependencies.
module pls_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/pls_addr_gen.sv -----
// pls_addr_gen: effective side and wrapped neighbor addresses of a site.
// Depends on pls_pkg.
module pls_addr_gen #(
  parameter int MAX_SIDE = 64
) (
  input  logic [pls_pkg::SIDE_W-1:0] side,
  input  logic [pls_pkg::POS_W-1:0]  row,
  input  logic [pls_pkg::POS_W-1:0]  col,
  output logic [(($clog2(MAX_SIDE+1) > pls_pkg::SIDE_W) ?
                 $clog2(MAX_SIDE+1) : pls_pkg::SIDE_W)-1:0] eff_side,
  output logic [pls_pkg::NB_COUNT-1:0][$clog2(MAX_SIDE*MAX_SIDE)-1:0] site_addr
);

  localparam int SW = ($clog2(MAX_SIDE+1) > pls_pkg::SIDE_W) ?
                      $clog2(MAX_SIDE+1) : pls_pkg::SIDE_W;
  localparam int AW = $clog2(MAX_SIDE*MAX_SIDE);

  logic [SW-1:0] s, r, c, r_up, r_dn, c_up, c_dn;

  function automatic logic [AW-1:0] lin(input logic [SW-1:0] rr, input logic [SW-1:0] cc);
    return AW'(rr * MAX_SIDE + cc);
  endfunction

  always_comb begin
    s = SW'(side);
    if (s < SW'(2)) begin
      s = SW'(2);
    end else if (s > SW'(MAX_SIDE)) begin
      s = SW'(MAX_SIDE);
    end
  end

  assign eff_side = s;
  assign r = SW'(row);
  assign c = SW'(col);

  // wrap at the side in use
  assign r_up = (r == '0) ? s - SW'(1) : r - SW'(1);
  assign r_dn = (r + SW'(1) >= s) ? '0 : r + SW'(1);
  assign c_up = (c == '0) ? s - SW'(1) : c - SW'(1);
  assign c_dn = (c + SW'(1) >= s) ? '0 : c + SW'(1);

  assign site_addr[pls_pkg::NB_A] = lin(r, c);
  assign site_addr[pls_pkg::NB_N] = lin(r_up, c);
  assign site_addr[pls_pkg::NB_E] = lin(r, c_dn);
  assign site_addr[pls_pkg::NB_S] = lin(r_dn, c);
  assign site_addr[pls_pkg::NB_W] = lin(r, c_up);

endmodule

// ----- rtl/core/pls_ctrl.sv -----
// pls_ctrl: item sequencer; read-modify-write of the site store, clearing
// pass and result assembly. Depends on pls_pkg and pls_addr_gen.
module pls_ctrl #(
  parameter int MAX_SIDE = 64
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  pls_pkg::cfg_t                           cfg,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [pls_pkg::MODE_W-1:0]              in_mode,
  input  logic [pls_pkg::POS_W-1:0]               in_row,
  input  logic [pls_pkg::POS_W-1:0]               in_col,
  input  logic                                    in_direction,
  input  logic [pls_pkg::SAMPLE_W-1:0]            in_sample,
  output logic                                    rd_en,
  output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]    rd_addr,
  input  logic [pls_pkg::SITE_W-1:0]              rd_data,
  output logic                                    wr_en,
  output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]    wr_addr,
  output logic [pls_pkg::SITE_W-1:0]              wr_data,
  output logic                                    res_valid,
  input  logic                                    res_ready,
  output pls_pkg::res_t                           res
);

  localparam int SW = ($clog2(MAX_SIDE+1) > pls_pkg::SIDE_W) ?
                      $clog2(MAX_SIDE+1) : pls_pkg::SIDE_W;
  localparam int AW = $clog2(MAX_SIDE*MAX_SIDE);
  localparam logic [AW-1:0] CLR_LAST = AW'(MAX_SIDE*MAX_SIDE - 1);

  pls_pkg::state_t state_r, state_nxt;
  pls_pkg::op_t    op_r;
  logic [pls_pkg::STEP_W-1:0] step_r, step_nxt, last_r, rd_tag_r;
  logic [pls_pkg::POS_W-1:0]  row_r, col_r;
  logic                       dir_r, hit_r, rd_pend_r;
  logic [pls_pkg::SITE_W-1:0] cen_r, oth_r;
  logic [3:0]                 nb_r;
  logic [AW-1:0]              clr_cnt_r;

  logic [SW-1:0] eff_side;
  logic [pls_pkg::NB_COUNT-1:0][AW-1:0] site_addr;
  logic in_lattice, hit, accept;
  logic [AW-1:0] part_addr;
  logic [pls_pkg::STEP_W-1:0] wlast;

  pls_addr_gen #(.MAX_SIDE(MAX_SIDE)) u_addr (
    .side     (cfg.side),
    .row      (row_r),
    .col      (col_r),
    .eff_side (eff_side),
    .site_addr(site_addr)
  );

  assign in_lattice = (SW'(in_row) < eff_side) && (SW'(in_col) < eff_side);
  assign hit    = {1'b0, in_sample} < cfg.threshold;
  assign accept = in_valid && in_ready;
  assign part_addr = dir_r ? site_addr[pls_pkg::NB_E] : site_addr[pls_pkg::NB_N];
  assign wlast  = (op_r == pls_pkg::OP_BOND_SET) ? pls_pkg::STEP_ONE : pls_pkg::STEP_ZERO;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pls_pkg::ST_CLEAR: begin
        if (clr_cnt_r == CLR_LAST) state_nxt = pls_pkg::ST_IDLE;
      end
      pls_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_mode)
            pls_pkg::MODE_CLEAR:  state_nxt = pls_pkg::ST_CLEAR;
            pls_pkg::MODE_SAMPLE: begin
              if (in_lattice && (!cfg.kind || hit)) state_nxt = pls_pkg::ST_READ;
            end
            pls_pkg::MODE_READ: begin
              state_nxt = in_lattice ? pls_pkg::ST_READ : pls_pkg::ST_DONE;
            end
            default: state_nxt = pls_pkg::ST_IDLE;
          endcase
        end
      end
      pls_pkg::ST_READ: begin
        if (step_r == last_r) state_nxt = pls_pkg::ST_WAIT;
      end
      pls_pkg::ST_WAIT: begin
        if (op_r == pls_pkg::OP_SITE_SET || op_r == pls_pkg::OP_BOND_SET) begin
          state_nxt = pls_pkg::ST_WRITE;
        end else begin
          state_nxt = pls_pkg::ST_DONE;
        end
      end
      pls_pkg::ST_WRITE: begin
        if (step_r == wlast) state_nxt = pls_pkg::ST_IDLE;
      end
      pls_pkg::ST_DONE: begin
        if (res_ready) state_nxt = pls_pkg::ST_IDLE;
      end
      default: state_nxt = pls_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = site_addr[pls_pkg::NB_A];
    wr_en     = 1'b0;
    wr_addr   = site_addr[pls_pkg::NB_A];
    wr_data   = '0;
    res_valid = 1'b0;
    res       = '0;
    case (state_r)
      pls_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_r;
      end
      pls_pkg::ST_IDLE: in_ready = 1'b1;
      pls_pkg::ST_READ: begin
        rd_en = 1'b1;
        if (op_r == pls_pkg::OP_BOND_SET && step_r == pls_pkg::STEP_ONE) begin
          rd_addr = part_addr;
        end else begin
          case (step_r)
            pls_pkg::NB_N: rd_addr = site_addr[pls_pkg::NB_N];
            pls_pkg::NB_E: rd_addr = site_addr[pls_pkg::NB_E];
            pls_pkg::NB_S: rd_addr = site_addr[pls_pkg::NB_S];
            pls_pkg::NB_W: rd_addr = site_addr[pls_pkg::NB_W];
            default:       rd_addr = site_addr[pls_pkg::NB_A];
          endcase
        end
      end
      pls_pkg::ST_WRITE: begin
        wr_en = 1'b1;
        if (op_r == pls_pkg::OP_SITE_SET) begin
          wr_data = {cen_r[pls_pkg::SITE_W-1:1], hit_r};
        end else if (step_r == pls_pkg::STEP_ZERO) begin
          wr_data = cen_r;
          wr_data[pls_pkg::OCC_BIT] = 1'b1;
          if (dir_r) wr_data[pls_pkg::BOND_E_BIT] = 1'b1;
          else       wr_data[pls_pkg::BOND_N_BIT] = 1'b1;
        end else begin
          wr_addr = part_addr;
          wr_data = oth_r;
          wr_data[pls_pkg::OCC_BIT] = 1'b1;
          if (dir_r) wr_data[pls_pkg::BOND_W_BIT] = 1'b1;
          else       wr_data[pls_pkg::BOND_S_BIT] = 1'b1;
        end
      end
      pls_pkg::ST_DONE: begin
        res_valid = res_ready;
        case (op_r)
          pls_pkg::OP_READ_SITE: begin
            res.occupied   = cen_r[pls_pkg::OCC_BIT];
            res.bond_north = cen_r[pls_pkg::OCC_BIT] & nb_r[0];
            res.bond_east  = cen_r[pls_pkg::OCC_BIT] & nb_r[1];
            res.bond_south = cen_r[pls_pkg::OCC_BIT] & nb_r[2];
            res.bond_west  = cen_r[pls_pkg::OCC_BIT] & nb_r[3];
          end
          pls_pkg::OP_READ_BOND: begin
            res.occupied   = cen_r[pls_pkg::OCC_BIT];
            res.bond_north = cen_r[pls_pkg::BOND_N_BIT];
            res.bond_east  = cen_r[pls_pkg::BOND_E_BIT];
            res.bond_south = cen_r[pls_pkg::BOND_S_BIT];
            res.bond_west  = cen_r[pls_pkg::BOND_W_BIT];
          end
          default: res = '0;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    step_nxt = pls_pkg::STEP_ZERO;
    if ((state_r == pls_pkg::ST_READ && step_r != last_r) ||
        (state_r == pls_pkg::ST_WRITE && step_r != wlast)) begin
      step_nxt = step_r + pls_pkg::STEP_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= pls_pkg::ST_CLEAR;
      clr_cnt_r <= '0;
      step_r    <= pls_pkg::STEP_ZERO;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      step_r    <= step_nxt;
      rd_pend_r <= (state_r == pls_pkg::ST_READ);
      if (accept && in_mode == pls_pkg::MODE_CLEAR) begin
        clr_cnt_r <= '0;
      end else if (state_r == pls_pkg::ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
    end
  end

  // item fields and captured words
  always_ff @(posedge clk) begin
    rd_tag_r <= step_r;
    if (accept) begin
      row_r <= in_row;
      col_r <= in_col;
      dir_r <= in_direction;
      hit_r <= hit;
      if (in_mode == pls_pkg::MODE_SAMPLE) begin
        op_r   <= cfg.kind ? pls_pkg::OP_BOND_SET : pls_pkg::OP_SITE_SET;
        last_r <= cfg.kind ? pls_pkg::STEP_ONE : pls_pkg::STEP_ZERO;
      end else begin
        op_r   <= !in_lattice ? pls_pkg::OP_READ_ZERO :
                  (cfg.kind ? pls_pkg::OP_READ_BOND : pls_pkg::OP_READ_SITE);
        last_r <= cfg.kind ? pls_pkg::STEP_ZERO : pls_pkg::NB_W;
      end
    end
    if (rd_pend_r) begin
      case (rd_tag_r)
        pls_pkg::NB_A: cen_r <= rd_data;
        pls_pkg::NB_N: begin
          oth_r   <= rd_data;
          nb_r[0] <= rd_data[pls_pkg::OCC_BIT];
        end
        pls_pkg::NB_E: nb_r[1] <= rd_data[pls_pkg::OCC_BIT];
        pls_pkg::NB_S: nb_r[2] <= rd_data[pls_pkg::OCC_BIT];
        pls_pkg::NB_W: nb_r[3] <= rd_data[pls_pkg::OCC_BIT];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/percolation_lattice_seeder.sv -----
// percolation_lattice_seeder: top level; configuration registers, result
// register, site store and sequencer. Depends on pls_pkg, pls_ram, pls_ctrl.
//
// Keeps a toroidal lattice of up to MAX_SIDE x MAX_SIDE sites (occupied bit
// plus N/E/S/W bonds) in one synchronous RAM, one word per site.
// Input channel (in_*): clear (mode 0), apply sample (mode 1), read (mode 2).
// Result channel (out_*): one transfer per read item, none for the others.
// Config port: APB-style, threshold at 0x0, kind at 0x4, side at 0x8, pready
// tied high; to be written by the user only while idle, not enforced by the block.
// One item at a time, paced by the single RAM port pair; the steps of an item:
//   site-mode read: 5 reads, 1 drain, 1 result, 1 accept
//   bond-mode read: read of the site, drain, result, accept
//   site sample: read, drain, write, accept; bond hit: reads of the site and its
//   partner, drain, writes of both, accept; bond miss, out-of-range sample,
//   unused mode: accept only; out-of-range read: result, accept
// Clear item and reset: a clearing pass writes zero to every RAM word, with
// in_ready low throughout.
// The result register decouples the output: the sequencer takes a new item
// while a result waits; a following read stalls only in its final cycle
// until out_ready frees the register.
module percolation_lattice_seeder #(
  parameter int MAX_SIDE = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [pls_pkg::MODE_W-1:0]     in_mode,
  input  logic [pls_pkg::POS_W-1:0]      in_row,
  input  logic [pls_pkg::POS_W-1:0]      in_col,
  input  logic                           in_direction,
  input  logic [pls_pkg::SAMPLE_W-1:0]   in_sample,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_occupied,
  output logic                           out_bond_north,
  output logic                           out_bond_east,
  output logic                           out_bond_south,
  output logic                           out_bond_west,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [3:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int AW = $clog2(MAX_SIDE*MAX_SIDE);

  pls_pkg::cfg_t cfg_r;
  pls_pkg::res_t out_res_r, res;
  logic          out_valid_r, res_valid, res_ready;

  logic                       rd_en, wr_en;
  logic [AW-1:0]              rd_addr, wr_addr;
  logic [pls_pkg::SITE_W-1:0] rd_data, wr_data;

  // config registers; store contents survive register writes
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold <= pls_pkg::THR_W'(32768);
      cfg_r.kind      <= 1'b0;
      cfg_r.side      <= pls_pkg::SIDE_W'(64);
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        pls_pkg::REG_THRESHOLD: cfg_r.threshold <= pwdata[pls_pkg::THR_W-1:0];
        pls_pkg::REG_KIND:      cfg_r.kind      <= pwdata[0];
        pls_pkg::REG_SIDE:      cfg_r.side      <= pwdata[pls_pkg::SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      pls_pkg::REG_THRESHOLD: prdata = 32'(cfg_r.threshold);
      pls_pkg::REG_KIND:      prdata = 32'(cfg_r.kind);
      pls_pkg::REG_SIDE:      prdata = 32'(cfg_r.side);
      default:                prdata = '0;
    endcase
  end

  pls_ram #(.WIDTH(pls_pkg::SITE_W), .DEPTH(MAX_SIDE*MAX_SIDE)) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  pls_ctrl #(.MAX_SIDE(MAX_SIDE)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_mode     (in_mode),
    .in_row      (in_row),
    .in_col      (in_col),
    .in_direction(in_direction),
    .in_sample   (in_sample),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // result register: free when empty or being drained this cycle
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) out_res_r <= res;
  end

  assign out_valid      = out_valid_r;
  assign out_occupied   = out_res_r.occupied;
  assign out_bond_north = out_res_r.bond_north;
  assign out_bond_east  = out_res_r.bond_east;
  assign out_bond_south = out_res_r.bond_south;
  assign out_bond_west  = out_res_r.bond_west;

endmodule

// ----- rtl/core/pls_checker.sv -----
// pls_checker: port-level assertions for percolation_lattice_seeder, with bind.
// Depends on pls_pkg and the top level's port names.
module pls_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [pls_pkg::MODE_W-1:0] in_mode,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_occupied
);

  // a held result stays presented
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_occupied))
    else $error("result dropped or changed while stalled");

  // clear and read items always leave the sequencer busy in the cycle after the transfer
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready &&
    (in_mode == pls_pkg::MODE_CLEAR || in_mode == pls_pkg::MODE_READ)
    |=> !in_ready)
    else $error("input taken right after a clear or read transfer");

  // a result is only produced out of the busy sequencer
  a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while sequencer idle");

  // clearing pass runs after reset
  a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_ready)
    else $error("input ready right after reset");

endmodule

bind percolation_lattice_seeder pls_checker u_pls_checker (.*);
